// File: hdl/cea_pkg.sv
package cea_pkg;

    // fixed field widths
    localparam int SZ_W    = 49;
    localparam int CFG_W   = 49;
    localparam int TAG_W   = 64;
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 4;

    // register byte addresses (8-byte slots)
    localparam logic [PADDR_W-1:0] ADDR_CAP  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_GRAN = 4'h8;

    localparam logic [CFG_W-1:0] CAP_RESET  = 49'd17179869184;
    localparam logic [CFG_W-1:0] GRAN_RESET = 49'd2097152;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_REL  = 2'd1,
        OP_LOOK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_INVALID  = 3'd1,
        STS_NOCAP    = 3'd2,
        STS_OVERLAP  = 3'd3,
        STS_NOTFOUND = 3'd4,
        STS_FULL     = 3'd5
    } t_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

// File: hdl/cea_req_if.sv
interface cea_req_if #(parameter int ADDR_BITS = 48);
    import cea_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic                 auto_place;
    logic [ADDR_BITS-1:0] base;
    logic [SZ_W-1:0]      size;
    logic [TAG_W-1:0]     tag;
    logic [TAG_W-1:0]     timestamp;

    modport source (output valid, operation, auto_place, base, size, tag, timestamp,
                    input ready);
    modport sink (input valid, operation, auto_place, base, size, tag, timestamp,
                  output ready);
endinterface

// File: hdl/cea_rsp_if.sv
interface cea_rsp_if #(parameter int ADDR_BITS = 48);
    import cea_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] result_base;
    logic [SZ_W-1:0]      result_size;
    logic [TAG_W-1:0]     result_tag;
    logic [TAG_W-1:0]     result_timestamp;

    modport source (output valid, status, result_base, result_size, result_tag,
                    result_timestamp, input ready);
    modport sink (input valid, status, result_base, result_size, result_tag,
                  result_timestamp, output ready);
endinterface

// File: hdl/cea_rem.sv
// Restoring remainder, one dividend bit per cycle.
module cea_rem import cea_pkg::*; #(
    parameter int DW = 52
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [CFG_W-1:0] i_divisor,
    output t_rem_stat        o_stat,
    output logic [CFG_W-1:0] o_rem
);
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_dvd, n_dvd;
    logic [CFG_W-1:0] r_rem, n_rem;
    logic [CFG_W:0]  trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[DW-1]};
        if (trial >= {1'b0, i_divisor}) begin
            trial = trial - {1'b0, i_divisor};
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(DW);
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = trial[CFG_W-1:0];
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// File: hdl/capacity_extent_allocator.sv
// Channel  | Dir | Handshake       | Item
// ---------+-----+-----------------+------------------------------------------------
// req      | in  | valid/ready     | operation, auto_place, base, size, tag, timestamp
// rsp      | out | valid/ready     | status, result_base, result_size, tag, timestamp
// apb      | in  | psel/penable    | 0x0 total_capacity, 0x8 granularity (49 bits)
//
// One item at a time; W = max(ADDR_BITS,49)+3 remainder bits, N = MAX_EXTENTS table slots.
// Lookup: scan. Release: round size, scan. Add at base: round size, align/range check,
// scan. Auto place: round size, then a scan and end rounding per extent stepped over.
// Cost is set by the bit-serial remainder unit and the one-slot-a-cycle table scan.
// Reset clears the valid bits and sets the tag counter to 1 at once; no clearing pass.
// A new item is taken while the previous result still waits in the output register.
module capacity_extent_allocator import cea_pkg::*; #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cea_req_if.sink            req,
    cea_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    // internal arithmetic width: base + size + rounding never overflows
    localparam int XW = ((ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W) + 3;
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [SZ_W-1:0] SZ_MASK = (ADDR_BITS + 1 >= SZ_W) ? {SZ_W{1'b1}} :
                                          SZ_W'((XW'(1) << (ADDR_BITS + 1)) - XW'(1));

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ASZ   = 8'b0000_0010,   // rounding the size
        S_ALGN  = 8'b0000_0100,   // base alignment check
        S_FIT   = 8'b0000_1000,   // first-fit: scan for next extent in base order
        S_FITR  = 8'b0001_0000,   // first-fit: round the end of that extent
        S_PLACE = 8'b0010_0000,   // range check of the chosen base
        S_CHK   = 8'b0100_0000,   // overlap / release / lookup scan
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [SZ_W-1:0]      size;
        logic [TAG_W-1:0]     tag;
        logic [TAG_W-1:0]     ts;
    } t_slot;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] base;
        logic [SZ_W-1:0]      size;
        logic [TAG_W-1:0]     tag;
        logic [TAG_W-1:0]     ts;
    } t_res;

    function automatic logic f_inside(input logic [XW-1:0] b, input logic [XW-1:0] s,
                                      input logic [XW-1:0] cap);
        logic hi_zero;
        hi_zero = ((b >> ADDR_BITS) == '0);
        return (s != '0) && (b < cap) && (s <= cap - b) && hi_zero;
    endfunction

    // ---------------- state ----------------
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic                r_auto, n_auto;
    logic [XW-1:0]       r_pb, n_pb;        // working base / address
    logic [XW-1:0]       r_s, n_s;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [TAG_W-1:0]    r_ts, n_ts;
    logic [XW-1:0]       r_as, n_as;        // aligned size
    logic [XW-1:0]       r_cand, n_cand;
    logic [XW-1:0]       r_prev, n_prev;
    logic                r_have_prev, n_have_prev;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_best_vld, n_best_vld;
    logic [XW-1:0]       r_best_base, n_best_base;
    logic [XW-1:0]       r_best_size, n_best_size;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_hit_idx, n_hit_idx;
    t_slot               r_hit_slot, n_hit_slot;
    logic                r_free_vld, n_free_vld;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    t_res                r_res, n_res;
    logic                r_do_wr, n_do_wr;
    logic                r_do_clr, n_do_clr;
    logic [TAG_W-1:0]    r_tag_cnt, n_tag_cnt;
    logic [MAX_EXTENTS-1:0] r_active, n_active;
    logic [CFG_W-1:0]    r_cap, n_cap;
    logic [CFG_W-1:0]    r_gran, n_gran;
    logic                r_ovld, n_ovld;
    t_res                r_out, n_out;

    // slot memory, registered read
    t_slot               r_mem [MAX_EXTENTS];
    t_slot               r_rdata;
    logic [IW-1:0]       rd_addr;
    logic                w_en;
    t_slot               w_data;

    // remainder unit
    logic                rem_start;
    logic [XW-1:0]       rem_dvd;
    t_rem_stat           rem_stat;
    logic [CFG_W-1:0]    rem_val;
    logic [CFG_W-1:0]    g_eff;

    // scan helpers
    logic [XW-1:0]       cap_x, g_x, sb, ss, end_x;
    logic                act, ovl, rel_m, cont, match, fit_c, scan_end, scan_go;
    logic                req_fire, done_go;
    logic [XW-1:0]       a_val;

    cea_rem #(.DW(XW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dvd),
        .i_divisor  (g_eff),
        .o_stat     (rem_stat),
        .o_rem      (rem_val)
    );

    assign g_eff    = (r_gran == '0) ? CFG_W'(1) : r_gran;
    assign cap_x    = XW'(r_cap);
    assign g_x      = XW'(g_eff);
    assign req.ready = (r_state == S_IDLE);
    assign req_fire = req.valid && req.ready;
    assign rd_addr  = (r_cnt == CW'(MAX_EXTENTS)) ? '0 : r_cnt[IW-1:0];
    assign scan_end = (r_cnt == CW'(MAX_EXTENTS)) && !r_rd_vld;
    assign done_go  = (r_state == S_DONE) && (!r_ovld || rsp.ready);

    // per-slot tests on the entry just read
    assign sb    = XW'(r_rdata.base);
    assign ss    = XW'(r_rdata.size);
    assign act   = r_rd_vld && r_active[r_rd_idx];
    assign ovl   = (ss != '0) && ((r_pb <= sb) ? (sb - r_pb < r_as) : (r_pb - sb < ss));
    assign rel_m = ((r_tag == '0) || (r_rdata.tag == r_tag)) && (sb == r_pb) && (ss == r_as);
    assign cont  = (r_s != '0) && (r_s <= ss) && (r_pb >= sb) && (r_pb - sb <= ss - r_s);
    assign fit_c = act && (!r_have_prev || sb > r_prev) && (!r_best_vld || sb < r_best_base);
    assign end_x = r_best_base + r_best_size;

    always_comb begin
        case (r_op)
            OP_ADD:  match = ovl;
            OP_REL:  match = rel_m;
            OP_LOOK: match = cont;
            default: match = 1'b0;
        endcase
    end

    // size rounded up to the granularity, or kept when it equals the capacity
    assign a_val = (r_s == cap_x) ? r_s :
                   r_s + ((rem_val != '0) ? (g_x - XW'(rem_val)) : '0);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_auto      = r_auto;
        n_pb        = r_pb;
        n_s         = r_s;
        n_tag       = r_tag;
        n_ts        = r_ts;
        n_as        = r_as;
        n_cand      = r_cand;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_best_vld  = r_best_vld;
        n_best_base = r_best_base;
        n_best_size = r_best_size;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_slot  = r_hit_slot;
        n_free_vld  = r_free_vld;
        n_free_idx  = r_free_idx;
        n_res       = r_res;
        n_do_wr     = r_do_wr;
        n_do_clr    = r_do_clr;
        n_tag_cnt   = r_tag_cnt;
        n_active    = r_active;
        n_cap       = r_cap;
        n_gran      = r_gran;
        n_ovld      = r_ovld && !rsp.ready;
        n_out       = r_out;
        rem_start   = 1'b0;
        rem_dvd     = r_s;
        scan_go     = 1'b0;
        w_en        = 1'b0;
        w_data.base = r_pb[ADDR_BITS-1:0];
        w_data.size = r_as[SZ_W-1:0];
        w_data.tag  = r_res.tag;
        w_data.ts   = r_ts;

        if (psel && penable && pwrite) begin
            // bit 3 picks the 8-byte register slot
            if (paddr[3] == ADDR_GRAN[3]) begin
                n_gran = pwdata[CFG_W-1:0];
            end else begin
                n_cap = pwdata[CFG_W-1:0];
            end
        end

        // scan stepping: issue one read a cycle, data arrives in the next cycle
        if (r_state == S_FIT || r_state == S_CHK) begin
            if (r_cnt != CW'(MAX_EXTENTS)) begin
                n_cnt    = r_cnt + CW'(1);
                n_rd_vld = 1'b1;
                n_rd_idx = r_cnt[IW-1:0];
            end else begin
                n_rd_vld = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op     = t_op'(req.operation);
                    n_auto   = req.auto_place;
                    n_pb     = XW'(req.base);
                    n_s      = XW'(req.size);
                    n_tag    = req.tag;
                    n_ts     = req.timestamp;
                    n_do_wr  = 1'b0;
                    n_do_clr = 1'b0;
                    n_res    = '{STS_INVALID, req.base, '0, '0, '0};
                    case (t_op'(req.operation))
                        OP_ADD, OP_REL: begin
                            rem_start = 1'b1;
                            rem_dvd   = XW'(req.size);
                            n_state   = S_ASZ;
                        end
                        OP_LOOK: begin
                            if (f_inside(XW'(req.base), XW'(req.size), cap_x)) begin
                                scan_go = 1'b1;
                                n_state = S_CHK;
                            end else begin
                                n_res.status = STS_NOTFOUND;
                                n_state      = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ASZ: begin
                if (rem_stat.done) begin
                    n_as = a_val;
                    if (r_op == OP_REL) begin
                        if (f_inside(r_pb, a_val, cap_x)) begin
                            scan_go = 1'b1;
                            n_state = S_CHK;
                        end else begin
                            n_res   = '{STS_INVALID, r_pb[ADDR_BITS-1:0], '0, '0, '0};
                            n_state = S_DONE;
                        end
                    end else if (a_val == '0 || a_val > cap_x) begin
                        n_res   = '{STS_INVALID, '0, '0, r_tag, '0};
                        n_state = S_DONE;
                    end else if (r_auto) begin
                        n_cand      = '0;
                        n_have_prev = 1'b0;
                        scan_go     = 1'b1;
                        n_state     = S_FIT;
                    end else begin
                        rem_start = 1'b1;
                        rem_dvd   = r_pb;
                        n_state   = S_ALGN;
                    end
                end
            end
            S_ALGN: begin
                if (rem_stat.done) begin
                    if (rem_val != '0) begin
                        n_res   = '{STS_INVALID, r_pb[ADDR_BITS-1:0],
                                    r_as[SZ_W-1:0] & SZ_MASK, r_tag, '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_FIT: begin
                if (fit_c) begin
                    n_best_vld  = 1'b1;
                    n_best_base = sb;
                    n_best_size = ss;
                end
                if (scan_end) begin
                    if (!r_best_vld) begin
                        if (f_inside(r_cand, r_as, cap_x)) begin
                            n_pb    = r_cand;
                            n_state = S_PLACE;
                        end else begin
                            n_res   = '{STS_NOCAP, '0, r_as[SZ_W-1:0] & SZ_MASK, r_tag, '0};
                            n_state = S_DONE;
                        end
                    end else if (r_cand + r_as <= r_best_base) begin
                        n_pb    = r_cand;
                        n_state = S_PLACE;
                    end else begin
                        rem_start   = 1'b1;
                        rem_dvd     = end_x;
                        n_prev      = r_best_base;
                        n_have_prev = 1'b1;
                        n_state     = S_FITR;
                    end
                end
            end
            S_FITR: begin
                if (rem_stat.done) begin
                    n_cand  = end_x + ((rem_val != '0) ? (g_x - XW'(rem_val)) : '0);
                    scan_go = 1'b1;
                    n_state = S_FIT;
                end
            end
            S_PLACE: begin
                if (f_inside(r_pb, r_as, cap_x)) begin
                    scan_go = 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_res   = '{STS_NOCAP, r_pb[ADDR_BITS-1:0],
                                r_as[SZ_W-1:0] & SZ_MASK, r_tag, '0};
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                if (act && match && !r_hit) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_rd_idx;
                    n_hit_slot = r_rdata;
                end
                if (r_rd_vld && !r_active[r_rd_idx] && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_rd_idx;
                end
                if (scan_end) begin
                    n_state = S_DONE;
                    case (r_op)
                        OP_ADD: begin
                            n_res = '{STS_OK, r_pb[ADDR_BITS-1:0],
                                      r_as[SZ_W-1:0] & SZ_MASK, r_tag, '0};
                            if (r_hit) begin
                                n_res.status = STS_OVERLAP;
                            end else if (!r_free_vld) begin
                                n_res.status = STS_FULL;
                            end else begin
                                n_do_wr = 1'b1;
                                if (r_tag == '0) begin
                                    n_res.tag = r_tag_cnt;
                                end
                            end
                        end
                        OP_REL: begin
                            n_res    = '{r_hit ? STS_OK : STS_NOTFOUND,
                                         r_pb[ADDR_BITS-1:0], '0, '0, '0};
                            n_do_clr = r_hit;
                        end
                        default: begin
                            if (r_hit) begin
                                n_res = '{STS_OK, r_hit_slot.base, r_hit_slot.size & SZ_MASK,
                                          r_hit_slot.tag, r_hit_slot.ts};
                            end else begin
                                n_res = '{STS_NOTFOUND, r_pb[ADDR_BITS-1:0], '0, '0, '0};
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (done_go) begin
                    n_ovld  = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                    if (r_do_wr) begin
                        w_en                 = 1'b1;
                        n_active[r_free_idx] = 1'b1;
                        if (r_tag == '0) begin
                            n_tag_cnt = r_tag_cnt + TAG_W'(1);
                        end
                    end
                    if (r_do_clr) begin
                        n_active[r_hit_idx] = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (scan_go) begin
            n_cnt      = '0;
            n_rd_vld   = 1'b0;
            n_hit      = 1'b0;
            n_free_vld = 1'b0;
            n_best_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_do_wr   <= 1'b0;
            r_do_clr  <= 1'b0;
            r_tag_cnt <= TAG_W'(1);
            r_active  <= '0;
            r_cap     <= CAP_RESET;
            r_gran    <= GRAN_RESET;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_do_wr   <= n_do_wr;
            r_do_clr  <= n_do_clr;
            r_tag_cnt <= n_tag_cnt;
            r_active  <= n_active;
            r_cap     <= n_cap;
            r_gran    <= n_gran;
            r_ovld    <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_auto      <= n_auto;
        r_pb        <= n_pb;
        r_s         <= n_s;
        r_tag       <= n_tag;
        r_ts        <= n_ts;
        r_as        <= n_as;
        r_cand      <= n_cand;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_rd_idx    <= n_rd_idx;
        r_best_vld  <= n_best_vld;
        r_best_base <= n_best_base;
        r_best_size <= n_best_size;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_slot  <= n_hit_slot;
        r_free_vld  <= n_free_vld;
        r_free_idx  <= n_free_idx;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // slot memory: writes land only as an item retires, read data is used only during scans,
    // so a scan never sees a write in flight
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[r_free_idx] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign rsp.valid            = r_ovld;
    assign rsp.status           = r_out.status;
    assign rsp.result_base      = r_out.base;
    assign rsp.result_size      = r_out.size;
    assign rsp.result_tag       = r_out.tag;
    assign rsp.result_timestamp = r_out.ts;

    assign prdata = (paddr[3] == ADDR_GRAN[3]) ? PDATA_W'(r_gran) : PDATA_W'(r_cap);
    assign pready = 1'b1;

`ifndef SYNTHESIS
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("accepted item did not start");
    a_clr_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && r_do_clr) |-> r_active[r_hit_idx])
        else $error("release frees an inactive slot");
    a_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && r_do_wr) |-> !r_active[r_free_idx])
        else $error("add overwrites an active slot");
    a_rem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> !rem_stat.busy)
        else $error("remainder unit restarted while busy");
    a_rd_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_FIT || r_state == S_CHK))
        else $error("slot read outside a scan");
`endif

endmodule
